FILE: hw/rtl/sh24_pkg.sv
// Shared types and constants for the SipHash-2-4 keyed hash block.
// No dependencies; used by sh24_round and siphash_2_4_keyed_hash.
`timescale 1ns / 1ps

package sh24_pkg;

  // Four 64-bit SipHash lanes
  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  // Lane initialization constants
  localparam logic [63:0] INIT_ZERO  = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_ONE   = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_TWO   = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_THREE = 64'h7465646279746573;

  // Finalization flag XORed into lane two
  localparam logic [63:0] FINAL_FLAG = 64'h00000000000000ff;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 4'd1;

  // Bytes in a full message word
  localparam logic [3:0] WORD_BYTES_FULL = 4'd8;

endpackage

FILE: hw/rtl/sh24_round.sv
// One SipRound over the four lanes, combinational.
// Depends on sh24_pkg for the lane struct.
`timescale 1ns / 1ps

module sh24_round (
  input  sh24_pkg::lanes_t lanes_in,
  output sh24_pkg::lanes_t lanes_out
);

  always_comb begin
    logic [63:0] a0, a1, a2, a3;
    logic [63:0] b0, b1, b2, b3;
    // first half: two adds, two rotate-xors
    a0 = lanes_in.v0 + lanes_in.v1;
    a1 = {lanes_in.v1[50:0], lanes_in.v1[63:51]} ^ a0;
    a0 = {a0[31:0], a0[63:32]};
    a2 = lanes_in.v2 + lanes_in.v3;
    a3 = {lanes_in.v3[47:0], lanes_in.v3[63:48]} ^ a2;
    // second half
    b0 = a0 + a3;
    b3 = {a3[42:0], a3[63:43]} ^ b0;
    b2 = a2 + a1;
    b1 = {a1[46:0], a1[63:47]} ^ b2;
    b2 = {b2[31:0], b2[63:32]};
    lanes_out.v0 = b0;
    lanes_out.v1 = b1;
    lanes_out.v2 = b2;
    lanes_out.v3 = b3;
  end

endmodule

FILE: hw/rtl/siphash_2_4_keyed_hash.sv
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  message_word, word_bytes, last_word
// out       source     out_valid / out_stall hash_value
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One SipRound unit is shared and runs one round per cycle under a small sequencer.
// A full word keeps the block busy for the transfer and two rounds; a last word
// also runs the finalization rounds, after absorbing a tail block if it has 8 bytes.
// in_stall is high while a word is in work; the hash sits in an output register,
// so the next word is taken while the hash still waits on out_stall. A new hash
// waits in the done state, with in_stall high, until the previous one is taken.
// Synchronous active-high rst clears keys, lanes, byte count and message state.
// Depends on sh24_pkg and sh24_round.
`timescale 1ns / 1ps

module siphash_2_4_keyed_hash (
  input  logic                             clk,
  input  logic                             rst,
  // message words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [63:0]                      message_word,
  input  logic [3:0]                       word_bytes,
  input  logic                             last_word,
  // hash results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [63:0]                      hash_value,
  // key registers
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sh24_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       round_cnt;
  logic [63:0]      key_low;
  logic [63:0]      key_high;
  sh24_pkg::lanes_t lanes;
  sh24_pkg::lanes_t rnd;
  logic [7:0]       length_count;
  logic             in_message;
  logic [63:0]      msg;
  logic [63:0]      tail_blk;
  logic             pend_tail;
  logic             is_last;

  // accept-side decode
  logic             in_xfer;
  logic             full_word;
  sh24_pkg::lanes_t base_lanes;
  logic [7:0]       base_len;
  logic [7:0]       length_next;
  logic [63:0]      tail_data;
  logic [63:0]      tail_next;
  logic [63:0]      first_m;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // shared round unit
  sh24_round u_round (
    .lanes_in  (lanes),
    .lanes_out (rnd)
  );

  // first word of a message starts from the key
  always_comb begin
    if (in_message) begin
      base_lanes = lanes;
      base_len   = length_count;
    end else begin
      base_lanes.v0 = key_low  ^ sh24_pkg::INIT_ZERO;
      base_lanes.v1 = key_high ^ sh24_pkg::INIT_ONE;
      base_lanes.v2 = key_low  ^ sh24_pkg::INIT_TWO;
      base_lanes.v3 = key_high ^ sh24_pkg::INIT_THREE;
      base_len      = 8'd0;
    end
  end

  // tail block: valid bytes low, byte length in the top byte
  always_comb begin
    full_word = !last_word || (word_bytes >= sh24_pkg::WORD_BYTES_FULL);
    length_next = base_len + (full_word ? {4'd0, sh24_pkg::WORD_BYTES_FULL}
                                        : {4'd0, word_bytes});
    for (int b = 0; b < 8; b++) begin
      tail_data[8*b +: 8] = (4'(b) < word_bytes) ? message_word[8*b +: 8] : 8'd0;
    end
    tail_next = {length_next, (full_word ? 56'd0 : tail_data[55:0])};
    first_m   = full_word ? message_word : tail_next;
  end

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sh24_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        sh24_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      round_cnt    <= '0;
      lanes        <= '0;
      length_count <= '0;
      in_message   <= 1'b0;
      pend_tail    <= 1'b0;
      is_last      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // result valid: set when the hash is loaded, cleared on its transfer
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            lanes        <= '{v0: base_lanes.v0, v1: base_lanes.v1, v2: base_lanes.v2,
                              v3: base_lanes.v3 ^ first_m};
            msg          <= first_m;
            tail_blk     <= tail_next;
            pend_tail    <= last_word && full_word;
            is_last      <= last_word;
            length_count <= length_next;
            in_message   <= 1'b1;
            round_cnt    <= '0;
            state        <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (round_cnt == 2'd1) begin
            round_cnt <= '0;
            if (pend_tail) begin
              // full last word done, absorb the empty tail block
              lanes     <= '{v0: rnd.v0 ^ msg, v1: rnd.v1, v2: rnd.v2,
                             v3: rnd.v3 ^ tail_blk};
              msg       <= tail_blk;
              pend_tail <= 1'b0;
            end else if (is_last) begin
              lanes <= '{v0: rnd.v0 ^ msg, v1: rnd.v1,
                         v2: rnd.v2 ^ sh24_pkg::FINAL_FLAG, v3: rnd.v3};
              state <= ST_FINAL;
            end else begin
              lanes <= '{v0: rnd.v0 ^ msg, v1: rnd.v1, v2: rnd.v2, v3: rnd.v3};
              state <= ST_IDLE;
            end
          end else begin
            lanes     <= rnd;
            round_cnt <= round_cnt + 2'd1;
          end
        end
        ST_FINAL: begin
          lanes     <= rnd;
          round_cnt <= round_cnt + 2'd1;
          if (round_cnt == 2'd3) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            in_message <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      hash_value <= lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3;
    end
  end

endmodule

FILE: hw/rtl/sh24_checker.sv
// Port-level checks for the SipHash-2-4 keyed hash block, bound to the top level.
// Depends on sh24_pkg for the configuration index width.
`timescale 1ns / 1ps

module sh24_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             last_word,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [63:0]                      hash_value,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [sh24_pkg::CFG_INDEX_W-1:0] cfg_index
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_value))
    else $error("hash changed while stalled");

  // a transfer keeps the block busy for the two compression rounds
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again before rounds finished");

  // a last word still holds the block busy once finalization has begun
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_word |-> ##5 in_stall)
    else $error("finalization cut short");

  // a new hash only appears at the end of a busy stretch
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("hash raised without work");

  // key writes are always taken and carry a known index
  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready && !$isunknown(cfg_index))
    else $error("key write refused or index unknown");

endmodule

bind siphash_2_4_keyed_hash sh24_checker u_sh24_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_word  (last_word),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_index  (cfg_index)
);
